/* sv/swsc_pkg.sv */
// Shared types and constants for the shaped wave sample core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package swsc_pkg;

    localparam int PERIOD_W  = 24;
    localparam int SHAPE_W   = 17;
    localparam int POS_W     = 32;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int RAMP_Q_W  = 16;
    localparam int RAMP_D_W  = PERIOD_W + 1;
    localparam int GAIN_W    = 18;
    localparam int RAMP_N_W  = PERIOD_W + GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_SPAN = 2'd3;

    localparam logic [SHAPE_W-1:0]  Q16_ONE       = 17'd65536;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 24'd48000;
    localparam logic [SHAPE_W-1:0]  WIDTH_RESET   = 17'd32768;
    localparam logic [PERIOD_W-1:0] HALF_RESET    = 24'd24000;
    localparam logic [SAMPLE_W-1:0] AMP           = 16'd32767;
    localparam logic [GAIN_W-1:0]   RAMP_GAIN     = 18'd131068;
    localparam logic [15:0]         ROUND_ADD     = 16'hFFFF;

    typedef struct packed {
        logic [PERIOD_W-1:0] per;
        logic [PERIOD_W-1:0] half;
        logic [PERIOD_W-1:0] ls;
        logic [PERIOD_W-1:0] rs;
    } shape_t;

endpackage

`default_nettype wire

/* sv/shaped_wave_sample_core.sv */
// Shaped wave sample core: one Q1.15 sample of a square/saw/triangle wave per position.
// Stages: 32 modulo cells, a decide stage, a multiply stage, 16 ramp cells and the output register.
// Throughput is one transaction per cycle while the output is not stalled, set by the two division
// chains. Reset clears all valid flags and loads the power-on wave settings; derived breakpoints
// settle after a configuration write. Depends on swsc_pkg, swsc_div_cell, swsc_shape_regs.
`timescale 1ns / 1ps
`default_nettype none

module shaped_wave_sample_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [swsc_pkg::POS_W-1:0]     position,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [swsc_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                           cfg_wen,
    input  wire logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swsc_pkg::PERIOD_W-1:0]  cfg_data
);

    localparam int PW = swsc_pkg::PERIOD_W;
    localparam int DW = swsc_pkg::RAMP_D_W;
    localparam int QW = swsc_pkg::RAMP_Q_W;
    localparam int NW = swsc_pkg::RAMP_N_W;
    localparam int MODN = swsc_pkg::POS_W;

    swsc_pkg::shape_t shape;
    logic en;

    logic                       mv [MODN+1];
    logic [PW-1:0]              mr [MODN+1];
    logic [swsc_pkg::POS_W-1:0] mw [MODN+1];
    logic [PW-1:0]              md [MODN+1];

    logic          dec_valid_reg;
    logic          dec_hi_reg;
    logic [PW-1:0] dec_num_reg;
    logic [PW-1:0] dec_den_reg;
    logic          dec_hi_next;
    logic [PW-1:0] dec_num_next;
    logic [PW-1:0] dec_den_next;
    logic [PW-1:0] p;

    logic          mul_valid_reg;
    logic          mul_hi_reg;
    logic [DW-1:0] mul_rem_reg;
    logic [QW-1:0] mul_low_reg;
    logic [DW-1:0] mul_dvs_reg;
    logic [NW-1:0] ramp_n;

    logic          rv [QW+1];
    logic [DW-1:0] rr [QW+1];
    logic [QW-1:0] rw [QW+1];
    logic [DW-1:0] rd [QW+1];
    logic          hi_line_reg [QW+1];

    logic                         out_valid_reg;
    logic [swsc_pkg::SAMPLE_W-1:0] sample_reg;
    logic [swsc_pkg::SAMPLE_W-1:0] sample_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    swsc_shape_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .shape     (shape)
    );

    assign mv[0] = in_valid;
    assign mr[0] = '0;
    assign mw[0] = position;
    assign md[0] = shape.per;

    for (genvar i = 0; i < MODN; i++)
    begin : g_mod
        swsc_div_cell #(.DW(PW), .WW(swsc_pkg::POS_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (mv[i]),
            .in_rem    (mr[i]),
            .in_word   (mw[i]),
            .in_dvs    (md[i]),
            .out_valid (mv[i+1]),
            .out_rem   (mr[i+1]),
            .out_word  (mw[i+1]),
            .out_dvs   (md[i+1])
        );
    end

    always_comb
    begin
        p = mr[MODN];
        dec_hi_next  = 1'b0;
        dec_num_next = '0;
        dec_den_next = PW'(1);
        if (p < shape.half)
        begin
            if (p > shape.ls)
            begin
                dec_num_next = p - shape.ls;
                dec_den_next = shape.half - shape.ls;
            end
        end
        else
        begin
            dec_hi_next = 1'b1;
            if (p > shape.rs)
            begin
                dec_num_next = p - shape.rs;
                dec_den_next = md[MODN] - shape.rs;
            end
        end
        ramp_n = NW'(dec_num_reg) * NW'(swsc_pkg::RAMP_GAIN) + NW'(dec_den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dec_valid_reg <= mv[MODN];
            mul_valid_reg <= dec_valid_reg;
            out_valid_reg <= rv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_hi_reg  <= dec_hi_next;
            dec_num_reg <= dec_num_next;
            dec_den_reg <= dec_den_next;
            mul_hi_reg  <= dec_hi_reg;
            mul_rem_reg <= ramp_n[DW+QW-1:QW];
            mul_low_reg <= ramp_n[QW-1:0];
            mul_dvs_reg <= {dec_den_reg, 1'b0};
            sample_reg  <= sample_next;
        end
    end

    assign rv[0] = mul_valid_reg;
    assign rr[0] = mul_rem_reg;
    assign rw[0] = mul_low_reg;
    assign rd[0] = mul_dvs_reg;
    assign hi_line_reg[0] = mul_hi_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_ramp
        swsc_div_cell #(.DW(DW), .WW(QW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rv[j]),
            .in_rem    (rr[j]),
            .in_word   (rw[j]),
            .in_dvs    (rd[j]),
            .out_valid (rv[j+1]),
            .out_rem   (rr[j+1]),
            .out_word  (rw[j+1]),
            .out_dvs   (rd[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hi_line_reg[j+1] <= hi_line_reg[j];
            end
        end
    end

    assign sample_next = hi_line_reg[QW] ? (swsc_pkg::AMP - rw[QW])
                                         : (rw[QW] - swsc_pkg::AMP);

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    a_no_min_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != 16'sh8000)
        else $error("sample reached the unused code -32768");

    a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rv[QW] |-> rw[QW] != 16'hFFFF)
        else $error("ramp quotient exceeded full scale");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("new transaction accepted while the output is stalled");

    a_rs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid_reg |-> dec_num_reg < dec_den_reg || dec_num_reg == '0)
        else $error("ramp numerator not below its span");

endmodule

`default_nettype wire

/* sv/swsc_div_cell.sv */
// One restoring division cell: one quotient bit per cycle while en is high, handed to the next cell.
// Depends on swsc_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module swsc_div_cell #(
    parameter int DW = swsc_pkg::PERIOD_W,
    parameter int WW = swsc_pkg::POS_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [WW-1:0] in_word,
    input  wire logic [DW-1:0] in_dvs,
    output logic               out_valid,
    output logic [DW-1:0]      out_rem,
    output logic [WW-1:0]      out_word,
    output logic [DW-1:0]      out_dvs
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [WW-1:0] word_reg;
    logic [WW-1:0] word_next;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {in_rem, in_word[WW-1]};
        ge        = trial >= {1'b0, in_dvs};
        diff      = trial - {1'b0, in_dvs};
        rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
        word_next = {in_word[WW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
            dvs_reg  <= in_dvs;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_word  = word_reg;
    assign out_dvs   = dvs_reg;

endmodule

`default_nettype wire

/* sv/swsc_shape_regs.sv */
// Configuration registers and the derived breakpoints of the wave cycle.
// Depends on swsc_pkg for widths, register indexes and the shape_t struct.
`timescale 1ns / 1ps
`default_nettype none

module swsc_shape_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swsc_pkg::PERIOD_W-1:0]  cfg_data,
    output swsc_pkg::shape_t                    shape
);

    localparam int PROD_W = swsc_pkg::PERIOD_W + swsc_pkg::SHAPE_W;
    localparam int RS_W   = PROD_W + 1;

    logic [swsc_pkg::PERIOD_W-1:0] period_reg;
    logic [swsc_pkg::SHAPE_W-1:0]  width_reg;
    logic [swsc_pkg::SHAPE_W-1:0]  left_reg;
    logic [swsc_pkg::SHAPE_W-1:0]  right_reg;
    logic [swsc_pkg::PERIOD_W-1:0] half_reg;
    logic [swsc_pkg::PERIOD_W-1:0] ls_reg;
    logic [swsc_pkg::PERIOD_W-1:0] rs_reg;
    logic [swsc_pkg::PERIOD_W-1:0] per_eff;
    logic [swsc_pkg::SHAPE_W-1:0]  sat_data;
    logic [PROD_W-1:0]             half_prod;
    logic [PROD_W-1:0]             ls_prod;
    logic [RS_W-1:0]               rs_prod;
    logic [swsc_pkg::PERIOD_W-1:0] half_next;
    logic [swsc_pkg::PERIOD_W-1:0] ls_next;
    logic [swsc_pkg::PERIOD_W-1:0] rs_next;

    always_comb
    begin
        per_eff   = (period_reg == '0) ? swsc_pkg::PERIOD_W'(1) : period_reg;
        sat_data  = (cfg_data[swsc_pkg::SHAPE_W-1:0] > swsc_pkg::Q16_ONE)
                    ? swsc_pkg::Q16_ONE : cfg_data[swsc_pkg::SHAPE_W-1:0];
        half_prod = PROD_W'(per_eff) * PROD_W'(width_reg);
        half_next = half_prod[39:16];
        ls_prod   = PROD_W'(half_reg) * PROD_W'(left_reg);
        ls_next   = ls_prod[39:16];
        rs_prod   = RS_W'(per_eff - half_reg) * RS_W'(right_reg)
                    + RS_W'(swsc_pkg::ROUND_ADD);
        rs_next   = per_eff - rs_prod[39:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= swsc_pkg::PERIOD_RESET;
            width_reg  <= swsc_pkg::WIDTH_RESET;
            left_reg   <= '0;
            right_reg  <= '0;
            half_reg   <= swsc_pkg::HALF_RESET;
            ls_reg     <= '0;
            rs_reg     <= swsc_pkg::PERIOD_RESET;
        end
        else
        begin
            half_reg <= half_next;
            ls_reg   <= ls_next;
            rs_reg   <= rs_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    swsc_pkg::REG_PERIOD:    period_reg <= cfg_data;
                    swsc_pkg::REG_WIDTH:     width_reg  <= sat_data;
                    swsc_pkg::REG_RISE_HOLD: left_reg   <= sat_data;
                    swsc_pkg::REG_FALL_SPAN: right_reg  <= sat_data;
                    default:                 ;
                endcase
            end
        end
    end

    assign shape.per  = per_eff;
    assign shape.half = half_reg;
    assign shape.ls   = ls_reg;
    assign shape.rs   = rs_reg;

endmodule

`default_nettype wire
